// ===== rtl/msso_pkg.sv =====
// Shared types and constants for the magnetometer sample scaler.
`timescale 1ns / 1ps

package msso_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIENTATION = 2'd1;

  localparam int SENS_W   = 11;
  localparam int SAMPLE_W = 16;
  localparam logic [SENS_W-1:0] SENS_RESET = 11'd1090;
  localparam logic [SENS_W-1:0] SENS_MIN   = 11'd1;

  // Scale factor to milligauss
  localparam logic signed [10:0] MILLI = 11'sd1000;

  // Product of a 16-bit count and 1000 fits in 26 signed bits
  localparam int PROD_W = 26;

  // Divider: two quotient bits per stage over the whole dividend
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = PROD_W / BITS_PER_STAGE;

  // Lane: multiply, magnitude, divider stages, sign fix
  localparam int LANE_LAT = DIV_STAGES + 3;
  // Plus the orientation output register
  localparam int PIPE_LAT = LANE_LAT + 1;

  typedef enum logic [2:0] {
    ORIENT_ENU = 3'd0,
    ORIENT_SEU = 3'd1,
    ORIENT_WSU = 3'd2,
    ORIENT_NWU = 3'd3,
    ORIENT_ESD = 3'd4,
    ORIENT_SWD = 3'd5,
    ORIENT_WND = 3'd6,
    ORIENT_NED = 3'd7
  } orient_t;

  // Partial state of the restoring divider between stages
  typedef struct packed {
    logic [SENS_W-1:0] rem;
    logic [PROD_W-1:0] dq;   // dividend shifting out the top, quotient in at the bottom
    logic              neg;
  } div_state_t;

endpackage

// ===== rtl/magnetometer_sample_scale_orient.sv =====
// Top level: config registers, three scaling lanes, orientation merge, flow control.
// An accepted sample passes the multiply, magnitude, divider, sign-fix and orientation registers.
// Throughput: one sample per cycle while not stalled; three lanes each run a
//   13-stage divider (two quotient bits per stage) behind a multiply-by-1000 stage.
// The whole pipeline holds while a result waits at the output under stall.
// Reset: synchronous; clears stage valids, sensitivity to 1090, orientation to ENU.
`timescale 1ns / 1ps

module magnetometer_sample_scale_orient (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [msso_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [msso_pkg::SENS_W-1:0]          cfg_data,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [7:0]                           first_high,
  input  logic [7:0]                           first_low,
  input  logic [7:0]                           second_high,
  input  logic [7:0]                           second_low,
  input  logic [7:0]                           third_high,
  input  logic [7:0]                           third_low,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [msso_pkg::SAMPLE_W-1:0] axis_x,
  output logic signed [msso_pkg::SAMPLE_W-1:0] axis_y,
  output logic signed [msso_pkg::SAMPLE_W-1:0] axis_z
);

  logic [msso_pkg::SENS_W-1:0]          sensitivity;
  msso_pkg::orient_t                    orientation;
  logic [msso_pkg::SENS_W-1:0]          divisor;
  logic [msso_pkg::PIPE_LAT-1:0]        stage_valid;
  logic                                 en;
  logic                                 sample_accept;
  logic signed [msso_pkg::SAMPLE_W-1:0] scaled_a;
  logic signed [msso_pkg::SAMPLE_W-1:0] scaled_b;
  logic signed [msso_pkg::SAMPLE_W-1:0] scaled_c;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= msso_pkg::SENS_RESET;
      orientation <= msso_pkg::ORIENT_ENU;
    end else if (cfg_we) begin
      case (cfg_index)
        msso_pkg::CFG_SENSITIVITY: sensitivity <= cfg_data;
        msso_pkg::CFG_ORIENTATION: orientation <= msso_pkg::orient_t'(cfg_data[2:0]);
        default: ;
      endcase
    end
  end

  // Zero sensitivity acts as the lowest legal value
  assign divisor = (sensitivity == '0) ? msso_pkg::SENS_MIN : sensitivity;

  // Flow control: advance unless a finished result is held
  assign en            = !(result_valid && result_stall);
  assign sample_stall  = !en;
  assign sample_accept = sample_valid && en;
  assign result_valid  = stage_valid[msso_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[msso_pkg::PIPE_LAT-2:0], sample_accept};
    end
  end

  // Lanes
  msso_scale_lane u_lane_a (
    .clk     (clk),
    .en      (en),
    .high    (first_high),
    .low     (first_low),
    .divisor (divisor),
    .scaled  (scaled_a)
  );

  msso_scale_lane u_lane_b (
    .clk     (clk),
    .en      (en),
    .high    (second_high),
    .low     (second_low),
    .divisor (divisor),
    .scaled  (scaled_b)
  );

  msso_scale_lane u_lane_c (
    .clk     (clk),
    .en      (en),
    .high    (third_high),
    .low     (third_low),
    .divisor (divisor),
    .scaled  (scaled_c)
  );

  // Merge
  msso_orient u_orient (
    .clk         (clk),
    .en          (en),
    .orientation (orientation),
    .a           (scaled_a),
    .b           (scaled_b),
    .c           (scaled_c),
    .x           (axis_x),
    .y           (axis_y),
    .z           (axis_z)
  );

`ifndef SYNTHESIS
  // An accepted sample enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample_accept |=> stage_valid[0])
    else $error("accepted sample did not enter the pipeline");

  // A held pipeline keeps every stage valid unchanged
  a_hold_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_valid))
    else $error("stage valids moved while held");

  // A new result only follows a valid penultimate stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid[msso_pkg::PIPE_LAT-2]))
    else $error("result appeared without a sample behind it");

  // The divider never sees zero
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    divisor != '0)
    else $error("zero divisor");
`endif

endmodule

// ===== rtl/msso_scale_lane.sv =====
// One axis lane: byte assembly, scale by 1000, pipelined signed division.
`timescale 1ns / 1ps

module msso_scale_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [7:0]                          high,
  input  logic [7:0]                          low,
  input  logic [msso_pkg::SENS_W-1:0]         divisor,
  output logic signed [msso_pkg::SAMPLE_W-1:0] scaled
);

  // Two restoring-division steps
  function automatic msso_pkg::div_state_t div_step(
    input msso_pkg::div_state_t    st,
    input logic [msso_pkg::SENS_W-1:0] d
  );
    msso_pkg::div_state_t r;
    logic [msso_pkg::SENS_W:0] trial;
    logic [msso_pkg::SENS_W:0] diff;
    r = st;
    for (int i = 0; i < msso_pkg::BITS_PER_STAGE; i++) begin
      trial = {r.rem, r.dq[msso_pkg::PROD_W-1]};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
        r.rem = diff[msso_pkg::SENS_W-1:0];
        r.dq  = {r.dq[msso_pkg::PROD_W-2:0], 1'b1};
      end else begin
        r.rem = trial[msso_pkg::SENS_W-1:0];
        r.dq  = {r.dq[msso_pkg::PROD_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic signed [msso_pkg::SAMPLE_W-1:0] count;
  logic signed [msso_pkg::SAMPLE_W+10:0] prod_full;
  logic signed [msso_pkg::PROD_W-1:0]   prod;
  logic [msso_pkg::PROD_W-1:0]          prod_neg;
  msso_pkg::div_state_t                 stage [0:msso_pkg::DIV_STAGES];

  assign count     = signed'({high, low});
  assign prod_full = count * msso_pkg::MILLI;
  assign prod_neg  = '0 - prod;

  always_ff @(posedge clk) begin
    if (en) begin
      // scale to milligauss numerator
      prod <= prod_full[msso_pkg::PROD_W-1:0];

      // magnitude and sign into the divider
      stage[0].rem <= '0;
      stage[0].dq  <= prod[msso_pkg::PROD_W-1] ? prod_neg : prod;
      stage[0].neg <= prod[msso_pkg::PROD_W-1];

      // divider stages
      for (int s = 1; s <= msso_pkg::DIV_STAGES; s++) begin
        stage[s] <= div_step(stage[s-1], divisor);
      end

      // truncate toward zero, keep low 16 bits with wrap
      if (stage[msso_pkg::DIV_STAGES].neg) begin
        scaled <= signed'(16'd0 - stage[msso_pkg::DIV_STAGES].dq[msso_pkg::SAMPLE_W-1:0]);
      end else begin
        scaled <= signed'(stage[msso_pkg::DIV_STAGES].dq[msso_pkg::SAMPLE_W-1:0]);
      end
    end
  end

endmodule

// ===== rtl/msso_orient.sv =====
// Merge stage: permutes and negates the three lane results into output axes.
`timescale 1ns / 1ps

module msso_orient (
  input  logic                                 clk,
  input  logic                                 en,
  input  msso_pkg::orient_t                    orientation,
  input  logic signed [msso_pkg::SAMPLE_W-1:0] a,
  input  logic signed [msso_pkg::SAMPLE_W-1:0] b,
  input  logic signed [msso_pkg::SAMPLE_W-1:0] c,
  output logic signed [msso_pkg::SAMPLE_W-1:0] x,
  output logic signed [msso_pkg::SAMPLE_W-1:0] y,
  output logic signed [msso_pkg::SAMPLE_W-1:0] z
);

  logic                                 swap;
  logic [2:0]                           neg;   // {x, y, z}
  logic signed [msso_pkg::SAMPLE_W-1:0] x_src;
  logic signed [msso_pkg::SAMPLE_W-1:0] y_src;

  // Mapping table
  always_comb begin
    swap = 1'b0;
    neg  = 3'b000;
    case (orientation)
      msso_pkg::ORIENT_ENU: begin swap = 1'b0; neg = 3'b001; end
      msso_pkg::ORIENT_SEU: begin swap = 1'b1; neg = 3'b101; end
      msso_pkg::ORIENT_WSU: begin swap = 1'b0; neg = 3'b111; end
      msso_pkg::ORIENT_NWU: begin swap = 1'b1; neg = 3'b011; end
      msso_pkg::ORIENT_ESD: begin swap = 1'b0; neg = 3'b010; end
      msso_pkg::ORIENT_SWD: begin swap = 1'b1; neg = 3'b110; end
      msso_pkg::ORIENT_WND: begin swap = 1'b0; neg = 3'b100; end
      msso_pkg::ORIENT_NED: begin swap = 1'b1; neg = 3'b000; end
      default:              begin swap = 1'b0; neg = 3'b000; end
    endcase
  end

  // x from c and y from a, or the other way round
  assign x_src = swap ? a : c;
  assign y_src = swap ? c : a;

  // Output register; negation wraps at 16 bits
  always_ff @(posedge clk) begin
    if (en) begin
      x <= neg[2] ? -x_src : x_src;
      y <= neg[1] ? -y_src : y_src;
      z <= neg[0] ? -b : b;
    end
  end

endmodule

// ===== sim/magnetometer_sample_scale_orient_test.sv =====
// Self-checking testbench for the magnetometer sample scaler and orienter.
`timescale 1ns / 1ps

module magnetometer_sample_scale_orient_test;

  localparam int MILLIGAUSS_PER_GAUSS = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int BLOCKS_PER_PHASE = 4;
  localparam int ITEMS_PER_BLOCK = 25;
  // Indexes past the register list; writes there must be ignored
  localparam logic [msso_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [msso_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0] first_high;
    logic [7:0] first_low;
    logic [7:0] second_high;
    logic [7:0] second_low;
    logic [7:0] third_high;
    logic [7:0] third_low;
  } raw_sample_t;

  typedef struct packed {
    logic signed [msso_pkg::SAMPLE_W-1:0] x;
    logic signed [msso_pkg::SAMPLE_W-1:0] y;
    logic signed [msso_pkg::SAMPLE_W-1:0] z;
  } axes_t;

  typedef struct {
    logic [msso_pkg::SENS_W-1:0] sens;
    msso_pkg::orient_t           orient;
    raw_sample_t                 raw;
    bit                          typed;
    axes_t                       typed_axes;
  } directed_row_t;

  // Clock and block inputs
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [msso_pkg::CFG_INDEX_W-1:0] cfg_index = msso_pkg::CFG_SENSITIVITY;
  logic [msso_pkg::SENS_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic [7:0] first_high = 8'h00;
  logic [7:0] first_low = 8'h00;
  logic [7:0] second_high = 8'h00;
  logic [7:0] second_low = 8'h00;
  logic [7:0] third_high = 8'h00;
  logic [7:0] third_low = 8'h00;
  logic result_stall = 1'b0;

  // Block outputs
  logic sample_stall;
  logic result_valid;
  logic signed [msso_pkg::SAMPLE_W-1:0] axis_x;
  logic signed [msso_pkg::SAMPLE_W-1:0] axis_y;
  logic signed [msso_pkg::SAMPLE_W-1:0] axis_z;

  // Testbench state
  axes_t expected_axes[$];
  logic [msso_pkg::SENS_W-1:0] sens_mirror = msso_pkg::SENS_RESET;
  msso_pkg::orient_t orient_mirror = msso_pkg::ORIENT_ENU;
  bit sender_gaps_on = 1'b1;
  bit hold_off_req = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  // Directed samples; sensitivity 1000 passes counts through unchanged
  directed_row_t directed_table[] = '{
    '{11'd1090, msso_pkg::ORIENT_ENU, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd1090, msso_pkg::ORIENT_ENU, '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    // -1000 / 1090 truncates toward zero
    '{11'd1090, msso_pkg::ORIENT_NED, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd1000, msso_pkg::ORIENT_ENU, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{16'sd3, 16'sd1, -16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_SEU, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{-16'sd1, 16'sd3, -16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_WSU, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{-16'sd3, -16'sd1, -16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_NWU, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{16'sd1, -16'sd3, -16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_ESD, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{16'sd3, -16'sd1, 16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_SWD, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{-16'sd1, -16'sd3, 16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_WND, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{-16'sd3, 16'sd1, 16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_NED, '{8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03}, 1'b1,
      '{16'sd1, 16'sd3, 16'sd2}},
    '{11'd1000, msso_pkg::ORIENT_NED, '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{-16'sd32768, -16'sd1, 16'sd32767}},
    // Negating the most negative value wraps back onto itself
    '{11'd1000, msso_pkg::ORIENT_WSU, '{8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00}, 1'b1,
      '{-16'sd32768, -16'sd32768, -16'sd32768}},
    // Quotient overflow wraps
    '{11'd1, msso_pkg::ORIENT_ENU, '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h21}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    // Zero sensitivity acts as one
    '{11'd0, msso_pkg::ORIENT_ENU, '{8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd2047, msso_pkg::ORIENT_SWD, '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'h12, 8'h34}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd2047, msso_pkg::ORIENT_ESD, '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd1, msso_pkg::ORIENT_NWU, '{8'hAA, 8'h55, 8'h55, 8'hAA, 8'h0F, 8'hF0}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd1, msso_pkg::ORIENT_NWU, '{8'h55, 8'hAA, 8'hAA, 8'h55, 8'hF0, 8'h0F}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}},
    '{11'd1090, msso_pkg::ORIENT_SEU, '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF}, 1'b0,
      '{16'sd0, 16'sd0, 16'sd0}}
  };

  magnetometer_sample_scale_orient i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .first_high   (first_high),
    .first_low    (first_low),
    .second_high  (second_high),
    .second_low   (second_low),
    .third_high   (third_high),
    .third_low    (third_low),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .axis_x       (axis_x),
    .axis_y       (axis_y),
    .axis_z       (axis_z)
  );

  always #6 clk = ~clk;

  // One axis: count times 1000 over sensitivity, truncated, low 16 bits kept
  function automatic logic signed [msso_pkg::SAMPLE_W-1:0] scale_to_milligauss(
      logic [7:0] hi, logic [7:0] lo, logic [msso_pkg::SENS_W-1:0] sens);
    int count;
    int divisor;
    int quotient;
    count = $signed({hi, lo});
    divisor = (sens == '0) ? 1 : int'(sens);
    quotient = (count * MILLIGAUSS_PER_GAUSS) / divisor;
    return quotient[msso_pkg::SAMPLE_W-1:0];
  endfunction

  // Scale all three axes and apply the axis mapping
  function automatic axes_t orient_axes(raw_sample_t s, logic [msso_pkg::SENS_W-1:0] sens,
                                        msso_pkg::orient_t o);
    logic signed [msso_pkg::SAMPLE_W-1:0] a;
    logic signed [msso_pkg::SAMPLE_W-1:0] b;
    logic signed [msso_pkg::SAMPLE_W-1:0] c;
    axes_t r;
    a = scale_to_milligauss(s.first_high, s.first_low, sens);
    b = scale_to_milligauss(s.second_high, s.second_low, sens);
    c = scale_to_milligauss(s.third_high, s.third_low, sens);
    case (o)
      msso_pkg::ORIENT_ENU: r = '{c, a, -b};
      msso_pkg::ORIENT_SEU: r = '{-a, c, -b};
      msso_pkg::ORIENT_WSU: r = '{-c, -a, -b};
      msso_pkg::ORIENT_NWU: r = '{a, -c, -b};
      msso_pkg::ORIENT_ESD: r = '{c, -a, b};
      msso_pkg::ORIENT_SWD: r = '{-a, -c, b};
      msso_pkg::ORIENT_WND: r = '{-c, a, b};
      default:              r = '{a, c, b};
    endcase
    return r;
  endfunction

  // Random byte, with corner values now and then on the high byte
  function automatic logic [7:0] random_byte(bit high_byte);
    logic [7:0] v;
    if (high_byte && $urandom_range(0, 9) < 2) begin
      case ($urandom_range(0, 3))
        0: v = 8'h00;
        1: v = 8'h7F;
        2: v = 8'h80;
        default: v = 8'hFF;
      endcase
    end else begin
      v = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gaps_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one sample; entered and left at a falling edge
  task automatic send_sample(raw_sample_t s, axes_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    first_high <= s.first_high;
    first_low <= s.first_low;
    second_high <= s.second_high;
    second_low <= s.second_low;
    third_high <= s.third_high;
    third_low <= s.third_low;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_axes.push_back(want);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_axes.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Write both registers (orientation with junk upper bits) plus a stray index
  task automatic write_regs(logic [msso_pkg::SENS_W-1:0] sens, msso_pkg::orient_t orient);
    cfg_we <= 1'b1;
    cfg_index <= msso_pkg::CFG_SENSITIVITY;
    cfg_data <= sens;
    @(negedge clk);
    cfg_index <= msso_pkg::CFG_ORIENTATION;
    cfg_data <= {8'($urandom_range(0, 255)), orient};
    @(negedge clk);
    cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3;
    cfg_data <= msso_pkg::SENS_W'($urandom_range(0, 2047));
    @(negedge clk);
    cfg_we <= 1'b0;
    sens_mirror = sens;
    orient_mirror = orient;
  endtask

  task automatic check_axis(string axis_name, logic signed [msso_pkg::SAMPLE_W-1:0] want,
                            logic signed [msso_pkg::SAMPLE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", axis_name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: compare each transaction against the oldest expectation
  always @(posedge clk) begin
    axes_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_axes.size() == 0) begin
        $error("result transaction with nothing expected: x=%0d y=%0d z=%0d",
               axis_x, axis_y, axis_z);
        fail_count++;
      end else begin
        want = expected_axes.pop_front();
        check_axis("axis_x", want.x, axis_x);
        check_axis("axis_y", want.y, axis_y);
        check_axis("axis_z", want.z, axis_z);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side stall: random runs, plus one long hold on request
  initial begin : result_sink
    int run_left;
    int r;
    logic stall_val;
    run_left = 0;
    stall_val = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        run_left = 0;
      end
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          stall_val = 1'b0;
          run_left = $urandom_range(1, 8);
        end else if (r < 85) begin
          stall_val = 1'b1;
          run_left = $urandom_range(1, 3);
        end else if (r < 95) begin
          stall_val = 1'b0;
          run_left = $urandom_range(20, 60);
        end else begin
          stall_val = 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
      result_stall <= stall_val;
      run_left--;
    end
  end

  // Stimulus
  initial begin : sample_source
    directed_row_t row;
    raw_sample_t raw;
    axes_t want;
    logic [msso_pkg::SENS_W-1:0] sens;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (directed_table[i]) begin
      row = directed_table[i];
      if (row.sens != sens_mirror || row.orient != orient_mirror) begin
        drain();
        write_regs(row.sens, row.orient);
      end
      want = row.typed ? row.typed_axes : orient_axes(row.raw, sens_mirror, orient_mirror);
      send_sample(row.raw, want);
    end

    // Random phases, one register setting each
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: sens = 11'd1;
        1: sens = 11'd2047;
        2: sens = 11'd0;
        3: sens = 11'd1000;
        4, 5: sens = msso_pkg::SENS_W'($urandom_range(230, 1370));
        default: sens = msso_pkg::SENS_W'($urandom_range(0, 2047));
      endcase
      drain();
      write_regs(sens, msso_pkg::orient_t'(3'(p % 8)));
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        sender_gaps_on = ($urandom_range(0, 2) != 0);
        // Long receiver hold with back-to-back offers to fill the pipeline
        if (p == 0 && blk == 0) begin
          sender_gaps_on = 1'b0;
          hold_off_req = 1'b1;
        end
        repeat (ITEMS_PER_BLOCK) begin
          raw.first_high = random_byte(1'b1);
          raw.first_low = random_byte(1'b0);
          raw.second_high = random_byte(1'b1);
          raw.second_low = random_byte(1'b0);
          raw.third_high = random_byte(1'b1);
          raw.third_low = random_byte(1'b0);
          send_sample(raw, orient_axes(raw, sens_mirror, orient_mirror));
        end
      end
    end

    drain();
    repeat (msso_pkg::PIPE_LAT + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msso_pkg.sv
rtl/msso_scale_lane.sv
rtl/msso_orient.sv
rtl/magnetometer_sample_scale_orient.sv
sim/magnetometer_sample_scale_orient_test.sv
